// ===== sv/mpq_pkg.sv =====
`default_nettype none

package mpq_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int TOTAL_W = 7;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] priority_val;
    logic [31:0] arrival;
    logic [15:0] id;
    logic [15:0] service_time;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } ctrl_t;

  // strict rank order: larger priority, then earlier arrival
  function automatic logic ranks_above(entry_t a, entry_t b);
    logic res;
    if (a.priority_val != b.priority_val) begin
      res = a.priority_val > b.priority_val;
    end else begin
      res = a.arrival < b.arrival;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mpq_cell.sv =====
`default_nettype none

module mpq_cell (
  input  logic            clk,
  input  mpq_pkg::ctrl_t  ctrl,
  input  mpq_pkg::entry_t new_entry,
  input  logic            occupied,
  input  logic            left_take,
  input  mpq_pkg::entry_t left_entry,
  input  mpq_pkg::entry_t right_entry,
  output logic            take,
  output mpq_pkg::entry_t entry
);

  mpq_pkg::entry_t entry_next;

  assign take = ctrl.ins & (~occupied | mpq_pkg::ranks_above(new_entry, entry));

  always_comb begin
    entry_next = entry;
    if (ctrl.rem) begin
      entry_next = right_entry;
    end else if (take) begin
      entry_next = left_take ? left_entry : new_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// ===== sv/max_priority_queue_unit.sv =====
`default_nettype none

// Sorted priority queue of up to 64 entries held in a row of cells, the head
// entry always in the first cell. An insert is
// compared against all held entries in parallel and the chain shifts right
// behind the insertion point, a remove shifts the chain left by one. The
// result is registered and appears the cycle after the word is taken; a new
// word is taken every cycle unless the result register is held by out_stall.
// Entries of equal priority and arrival leave in insertion order. Inserts
// into a full queue and removes from an empty queue leave it unchanged and
// return zero data. No clearing pass is needed after reset.
module max_priority_queue_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [15:0] in_priority,
  input  logic [31:0] in_arrival,
  input  logic [15:0] in_id,
  input  logic [15:0] in_service_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] out_priority,
  output logic [31:0] out_arrival,
  output logic [15:0] out_id,
  output logic [15:0] out_service_time,
  output logic        now_empty,
  output logic [6:0]  entry_total
);

  localparam int N = mpq_pkg::CAPACITY;

  logic [mpq_pkg::CNT_W-1:0] count;
  logic [mpq_pkg::CNT_W-1:0] count_next;
  logic                      in_acc;
  logic                      full;
  logic                      empty;
  mpq_pkg::ctrl_t            ctrl;
  mpq_pkg::entry_t           new_entry;
  mpq_pkg::entry_t           head;
  mpq_pkg::status_t          status_next;
  mpq_pkg::entry_t           cells [N];
  logic [N-1:0]              takes;
  logic [N-1:0]              occ;

  assign in_stall = out_valid & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign full     = count == mpq_pkg::CNT_W'(N);
  assign empty    = count == '0;

  assign new_entry.priority_val = in_priority;
  assign new_entry.arrival      = in_arrival;
  assign new_entry.id           = in_id;
  assign new_entry.service_time = in_service_time;

  assign ctrl.ins = in_acc & (cmd == mpq_pkg::CMD_INSERT) & ~full;
  assign ctrl.rem = in_acc & (cmd == mpq_pkg::CMD_REMOVE) & ~empty;

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      mpq_pkg::entry_t left_e;
      mpq_pkg::entry_t right_e;
      logic            left_t;

      assign occ[gi] = mpq_pkg::CNT_W'(gi) < count;

      if (gi == 0) begin : g_first
        assign left_e = '0;
        assign left_t = 1'b0;
      end else begin : g_mid
        assign left_e = cells[gi-1];
        assign left_t = takes[gi-1];
      end

      if (gi == N - 1) begin : g_last
        assign right_e = cells[gi];
      end else begin : g_inner
        assign right_e = cells[gi+1];
      end

      mpq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .new_entry   (new_entry),
        .occupied    (occ[gi]),
        .left_take   (left_t),
        .left_entry  (left_e),
        .right_entry (right_e),
        .take        (takes[gi]),
        .entry       (cells[gi])
      );
    end
  endgenerate

  always_comb begin
    count_next  = count;
    status_next = mpq_pkg::ST_INSERTED;
    head        = '0;
    if (cmd == mpq_pkg::CMD_INSERT) begin
      if (full) begin
        status_next = mpq_pkg::ST_FULL;
      end else begin
        count_next = count + mpq_pkg::CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_next = mpq_pkg::ST_EMPTY;
      end else begin
        status_next = mpq_pkg::ST_REMOVED;
        head        = cells[0];
        count_next  = count - mpq_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        count <= count_next;
      end
      out_valid <= in_acc | (out_valid & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status           <= status_next;
      out_priority     <= head.priority_val;
      out_arrival      <= head.arrival;
      out_id           <= head.id;
      out_service_time <= head.service_time;
      now_empty        <= count_next == '0;
      entry_total      <= mpq_pkg::TOTAL_W'(count_next);
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= mpq_pkg::CNT_W'(N))
    else $error("entry count above capacity");

  a_head_order : assert property (@(posedge clk) disable iff (rst)
    (count >= mpq_pkg::CNT_W'(2)) |-> !mpq_pkg::ranks_above(cells[1], cells[0]))
    else $error("head cell outranked by second cell");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> count == $past(count) + mpq_pkg::CNT_W'(1))
    else $error("insert did not grow the count");

  a_empty_flag : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (now_empty == (entry_total == '0)))
    else $error("empty flag disagrees with total");

endmodule

`default_nettype wire

// ===== tb/tb_max_priority_queue_unit.sv =====
`default_nettype none

module tb_max_priority_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_WORDS = 200;

  typedef struct packed {
    logic            cmd;
    mpq_pkg::entry_t e;
  } word_t;

  typedef struct packed {
    mpq_pkg::status_t st;
    mpq_pkg::entry_t  data;
    logic             empty;
    logic [6:0]       total;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = mpq_pkg::CMD_INSERT;
  logic [15:0] in_priority = '0;
  logic [31:0] in_arrival = '0;
  logic [15:0] in_id = '0;
  logic [15:0] in_service_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] out_priority;
  logic [31:0] out_arrival;
  logic [15:0] out_id;
  logic [15:0] out_service_time;
  logic        now_empty;
  logic [6:0]  entry_total;

  max_priority_queue_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .in_priority(in_priority),
    .in_arrival(in_arrival),
    .in_id(in_id),
    .in_service_time(in_service_time),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .out_priority(out_priority),
    .out_arrival(out_arrival),
    .out_id(out_id),
    .out_service_time(out_service_time),
    .now_empty(now_empty),
    .entry_total(entry_total)
  );

  always #5 clk = ~clk;

  word_t           pending_words[$];
  outcome_t        due_results[$];
  word_t           cur_word;
  mpq_pkg::entry_t held[mpq_pkg::CAPACITY];
  int              held_count = 0;
  int              accepted_total = 0;
  int              mismatches = 0;
  int              phase = 0;
  int              cycles = 0;
  int              send_gap = 0;
  int              send_calm = 0;
  int              stall_left = 0;
  int              recv_calm = 0;
  int              hold_left = 0;
  bit              hold_done = 1'b0;

  function automatic bit in_tail();
    return (phase == 3) && (pending_words.size() <= TAIL_WORDS);
  endfunction

  function automatic bit beats(mpq_pkg::entry_t a, mpq_pkg::entry_t b);
    return (a.priority_val > b.priority_val) ||
           ((a.priority_val == b.priority_val) && (a.arrival < b.arrival));
  endfunction

  // sorted model: slot 0 holds the next entry to leave
  function automatic outcome_t serve_word(word_t w);
    outcome_t r;
    int slot;
    r = '0;
    if (w.cmd == mpq_pkg::CMD_INSERT) begin
      if (held_count >= mpq_pkg::CAPACITY) begin
        r.st = mpq_pkg::ST_FULL;
      end else begin
        slot = 0;
        while (slot < held_count && !beats(w.e, held[slot])) slot++;
        for (int i = held_count; i > slot; i--) held[i] = held[i-1];
        held[slot] = w.e;
        held_count++;
        r.st = mpq_pkg::ST_INSERTED;
      end
    end else begin
      if (held_count == 0) begin
        r.st = mpq_pkg::ST_EMPTY;
      end else begin
        r.data = held[0];
        for (int i = 1; i < held_count; i++) held[i-1] = held[i];
        held_count--;
        r.st = mpq_pkg::ST_REMOVED;
      end
    end
    r.empty = (held_count == 0);
    r.total = 7'(held_count);
    return r;
  endfunction

  task automatic push_word(logic c, logic [15:0] pri, logic [31:0] arr,
                           logic [15:0] id, logic [15:0] svc);
    word_t w;
    w.cmd = c;
    w.e.priority_val = pri;
    w.e.arrival = arr;
    w.e.id = id;
    w.e.service_time = svc;
    pending_words.push_back(w);
  endtask

  function automatic word_t random_word(int insert_pct);
    word_t w;
    w.cmd = ($urandom_range(0, 99) < insert_pct) ? mpq_pkg::CMD_INSERT : mpq_pkg::CMD_REMOVE;
    case ($urandom_range(0, 3))
      0: w.e.priority_val = 16'($urandom_range(0, 3));
      1: w.e.priority_val = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: w.e.priority_val = 16'($urandom());
    endcase
    case ($urandom_range(0, 3))
      0: w.e.arrival = 32'($urandom_range(0, 2));
      1: w.e.arrival = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: w.e.arrival = $urandom();
    endcase
    w.e.id = 16'($urandom());
    w.e.service_time = 16'($urandom());
    return w;
  endfunction

  // runs of filling, balanced and draining traffic
  task automatic queue_random(int n);
    int seg;
    int pct;
    while (n > 0) begin
      seg = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0: pct = 90;
        1: pct = 50;
        default: pct = 15;
      endcase
      for (int i = 0; i < seg && n > 0; i++) begin
        pending_words.push_back(random_word(pct));
        n--;
      end
    end
  endtask

  task automatic wait_sent();
    while (pending_words.size() != 0 || in_valid) @(posedge clk);
  endtask

  task automatic wait_results();
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(serve_word(cur_word));
        accepted_total++;
      end
      if (send_calm > 0) send_calm--;
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!in_tail() && send_calm == 0 && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else begin
          if (!in_tail() && send_calm == 0 && $urandom_range(0, 39) == 0)
            send_calm = $urandom_range(30, 150);
          cur_word = pending_words.pop_front();
          cmd <= cur_word.cmd;
          in_priority <= cur_word.e.priority_val;
          in_arrival <= cur_word.e.arrival;
          in_id <= cur_word.e.id;
          in_service_time <= cur_word.e.service_time;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (recv_calm > 0) recv_calm--;
      if (!hold_done && phase == 2 && accepted_total >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (in_tail() || recv_calm > 0) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 39) == 0) recv_calm = $urandom_range(30, 150);
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status=%0d total=%0d", status, entry_total);
      end else begin
        outcome_t exp;
        exp = due_results.pop_front();
        if (status !== exp.st || out_priority !== exp.data.priority_val ||
            out_arrival !== exp.data.arrival || out_id !== exp.data.id ||
            out_service_time !== exp.data.service_time || now_empty !== exp.empty ||
            entry_total !== exp.total) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: st=%0d pri=%h arr=%h id=%h svc=%h empty=%0d total=%0d",
                     exp.st, exp.data.priority_val, exp.data.arrival, exp.data.id,
                     exp.data.service_time, exp.empty, exp.total);
            $display("         got: st=%0d pri=%h arr=%h id=%h svc=%h empty=%0d total=%0d",
                     status, out_priority, out_arrival, out_id, out_service_time,
                     now_empty, entry_total);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    phase = 1;
    push_word(mpq_pkg::CMD_REMOVE, 16'h0, 32'h0, 16'h0, 16'h0);
    push_word(mpq_pkg::CMD_INSERT, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000);
    push_word(mpq_pkg::CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    push_word(mpq_pkg::CMD_INSERT, 16'hFFFF, 32'h0000_0000, 16'h1234, 16'h0001);
    // full tie goes behind the one already held
    push_word(mpq_pkg::CMD_INSERT, 16'hFFFF, 32'h0000_0000, 16'h5678, 16'h0002);
    push_word(mpq_pkg::CMD_INSERT, 16'h8000, 32'h0000_0007, 16'h00AA, 16'h0003);
    push_word(mpq_pkg::CMD_INSERT, 16'h8000, 32'h0000_0003, 16'h00BB, 16'h0004);
    push_word(mpq_pkg::CMD_INSERT, 16'h0000, 32'hFFFF_FFFF, 16'h00CC, 16'h0005);
    repeat (7) push_word(mpq_pkg::CMD_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    push_word(mpq_pkg::CMD_REMOVE, 16'h0, 32'h0, 16'h0, 16'h0);
    // fill past capacity so the last two inserts are refused
    for (int i = 0; i < mpq_pkg::CAPACITY + 2; i++)
      push_word(mpq_pkg::CMD_INSERT, 16'(i % 3), 32'(i % 2), 16'(i), 16'(i * 7));
    repeat (mpq_pkg::CAPACITY + 2) push_word(mpq_pkg::CMD_REMOVE, 16'h0, 32'h0, 16'h0, 16'h0);
    wait_sent();
    wait_results();

    phase = 2;
    queue_random(700);
    wait_sent();
    // sender holds back until the queue has answered everything
    wait_results();

    phase = 3;
    queue_random(700);
    wait_sent();
    wait_results();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
